FILE: src/anbf_pkg.sv
// anbf_pkg: types and constants shared by the annex b unit framer modules
// no dependencies

package anbf_pkg;

    localparam int MAX_ZEROS = 31;
    localparam int ZR_W      = $clog2(MAX_ZEROS + 1);
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_EOS  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_START,
        OP_FLUSH
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HELD,
        BK_ZERO
    } t_back_state;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       unit_first;
        logic       unit_last;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        t_op             op;
        logic [ZR_W-1:0] nz;
        logic [7:0]      data_byte;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: src/anbf_front.sv
// anbf_front: accepts stream bytes, counts zero runs, classifies each byte
// and pushes a command to the back end for those that yield output; depends on anbf_pkg

module anbf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  anbf_pkg::t_in_item  i_in_item,
    input  anbf_pkg::t_q_stat   i_q_stat,
    output logic                o_push,
    output anbf_pkg::t_cmd      o_cmd
);

    logic [anbf_pkg::ZR_W-1:0] r_zero_run, n_zero_run;
    logic                      r_inside, n_inside;
    logic                      accept;

    assign o_in_ready = !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_zero_run        = r_zero_run;
        n_inside          = r_inside;
        o_push            = 1'b0;
        o_cmd.op          = anbf_pkg::OP_DATA;
        o_cmd.nz          = r_zero_run;
        o_cmd.data_byte   = i_in_item.data_byte;
        if (accept) begin
            if (i_in_item.kind == anbf_pkg::KIND_EOS) begin
                o_cmd.op   = anbf_pkg::OP_FLUSH;
                o_push     = r_inside;
                n_zero_run = '0;
                n_inside   = 1'b0;
            end else if (i_in_item.data_byte == anbf_pkg::BYTE_ZERO) begin
                if (r_zero_run < anbf_pkg::ZR_W'(anbf_pkg::MAX_ZEROS)) begin
                    n_zero_run = r_zero_run + 1'b1;
                end else begin
                    // excess zero of a long run goes into the current unit, if one is open
                    o_cmd.nz = '0;
                    o_push   = r_inside;
                end
            end else if (i_in_item.data_byte == anbf_pkg::BYTE_ONE &&
                         r_zero_run >= anbf_pkg::ZR_W'(2)) begin
                o_cmd.op   = anbf_pkg::OP_START;
                o_push     = 1'b1;
                n_inside   = 1'b1;
                n_zero_run = '0;
            end else begin
                o_push     = r_inside;
                n_zero_run = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= '0;
            r_inside   <= 1'b0;
        end else begin
            r_zero_run <= n_zero_run;
            r_inside   <= n_inside;
        end
    end

endmodule

FILE: src/anbf_queue.sv
// anbf_queue: short command queue between front and back end
// depends on anbf_pkg

module anbf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  anbf_pkg::t_cmd     i_cmd,
    input  logic               i_pop,
    output anbf_pkg::t_cmd     o_cmd,
    output anbf_pkg::t_q_stat  o_stat
);

    anbf_pkg::t_cmd              r_mem [anbf_pkg::QDEPTH];
    logic [anbf_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [anbf_pkg::QPTR_W:0]   r_count;
    logic                        do_push, do_pop;

    assign o_stat.full  = (r_count == (anbf_pkg::QPTR_W+1)'(anbf_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/anbf_back.sv
// anbf_back: runs queued commands, one output byte per cycle while the receiver accepts,
// and keeps the delayed byte that carries the end-of-unit mark; depends on anbf_pkg

module anbf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  anbf_pkg::t_cmd      i_cmd,
    input  anbf_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output anbf_pkg::t_out_item o_out_item
);

    anbf_pkg::t_back_state      r_state, n_state;
    anbf_pkg::t_op              r_op, n_op;
    logic [anbf_pkg::ZR_W-1:0]  r_rem, n_rem;
    logic [7:0]                 r_byte, n_byte;
    logic                       r_zfirst, n_zfirst;
    logic [7:0]                 r_held_byte, n_held_byte;
    logic                       r_held_first, n_held_first;
    logic                       r_held_valid, n_held_valid;
    logic                       r_o_valid, n_o_valid;
    anbf_pkg::t_out_item        r_o_item, n_o_item;
    logic                       slot_free, emit, done, can_load;

    assign slot_free   = !r_o_valid || i_out_ready;
    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_rem        = r_rem;
        n_byte       = r_byte;
        n_zfirst     = r_zfirst;
        n_held_byte  = r_held_byte;
        n_held_first = r_held_first;
        n_held_valid = r_held_valid;
        n_o_item     = r_o_item;
        emit         = 1'b0;
        done         = 1'b0;
        o_pop        = 1'b0;

        case (r_state)
            anbf_pkg::BK_HELD: begin
                if (slot_free) begin
                    emit                = 1'b1;
                    n_o_item.out_byte   = r_held_byte;
                    n_o_item.unit_first = r_held_first;
                    n_o_item.unit_last  = (r_op == anbf_pkg::OP_START) ||
                                          (r_op == anbf_pkg::OP_FLUSH && r_rem == '0);
                    n_o_item.run_last   = (r_rem == '0);
                    n_held_valid        = 1'b0;
                    if (r_rem == '0) begin
                        done = 1'b1;
                    end else begin
                        n_state = anbf_pkg::BK_ZERO;
                    end
                end
            end
            anbf_pkg::BK_ZERO: begin
                if (slot_free) begin
                    emit                = 1'b1;
                    n_o_item.out_byte   = anbf_pkg::BYTE_ZERO;
                    n_o_item.unit_first = (r_op == anbf_pkg::OP_START) && r_zfirst;
                    n_o_item.unit_last  = (r_op == anbf_pkg::OP_FLUSH) &&
                                          (r_rem == anbf_pkg::ZR_W'(1));
                    n_o_item.run_last   = (r_rem == anbf_pkg::ZR_W'(1));
                    n_zfirst            = 1'b0;
                    n_rem               = r_rem - 1'b1;
                    if (r_rem == anbf_pkg::ZR_W'(1)) begin
                        done = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (done) begin
            n_state = anbf_pkg::BK_IDLE;
            case (r_op)
                anbf_pkg::OP_DATA: begin
                    n_held_byte  = r_byte;
                    n_held_first = 1'b0;
                    n_held_valid = 1'b1;
                end
                anbf_pkg::OP_START: begin
                    n_held_byte  = anbf_pkg::BYTE_ONE;
                    n_held_first = 1'b0;
                    n_held_valid = 1'b1;
                end
                default: begin
                    n_held_first = 1'b0;
                    n_held_valid = 1'b0;
                end
            endcase
        end

        can_load = (r_state == anbf_pkg::BK_IDLE) || done;
        if (can_load && !i_q_stat.empty) begin
            o_pop    = 1'b1;
            n_op     = i_cmd.op;
            n_rem    = i_cmd.nz;
            n_byte   = i_cmd.data_byte;
            n_zfirst = 1'b1;
            n_state  = n_held_valid ? anbf_pkg::BK_HELD : anbf_pkg::BK_ZERO;
        end

        if (emit) begin
            n_o_valid = 1'b1;
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= anbf_pkg::BK_IDLE;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held_valid <= n_held_valid;
            r_held_first <= n_held_first;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_rem       <= n_rem;
        r_byte      <= n_byte;
        r_zfirst    <= n_zfirst;
        r_held_byte <= n_held_byte;
        r_o_item    <= n_o_item;
    end

endmodule

FILE: src/annexb_nal_unit_framer.sv
// annexb_nal_unit_framer: top level, front end, command queue and back end
// depends on anbf_pkg, anbf_front, anbf_queue, anbf_back

// Splits a byte stream into units that each begin at a start code (two or more
// zeros then 0x01); bytes before the first start code are dropped and an
// end-of-stream item flushes the open unit. The front end takes one input item
// per cycle while the four-entry command queue has room; the back end then
// turns each queued command into its output bytes, up to 32 for a start code
// or flush after a long zero run, and items that yield nothing are never queued.
// Output bytes sit in one register; while the receiver stalls, the back end
// waits and the front end keeps taking items until the queue is full.

module annexb_nal_unit_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  anbf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output anbf_pkg::t_out_item o_out_item
);

    logic              push, pop;
    anbf_pkg::t_cmd    push_cmd, head_cmd;
    anbf_pkg::t_q_stat q_stat;

    anbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    anbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    anbf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: src/anbf_checker.sv
// anbf_checker: port-level checks for annexb_nal_unit_framer, bound to the top
// depends on anbf_pkg

module anbf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input anbf_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input anbf_pkg::t_out_item o_out_item
);

    // stalled transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input transaction changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a unit opens on a start code zero
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.unit_first |-> o_out_item.out_byte == anbf_pkg::BYTE_ZERO)
        else $error("unit opens on a nonzero byte");

    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.unit_first && o_out_item.unit_last))
        else $error("unit of one byte");

endmodule

bind annexb_nal_unit_framer anbf_checker u_anbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

FILE: tb/annexb_nal_unit_framer_tb.sv
// annexb_nal_unit_framer_tb: random and directed byte streams into the unit framer,
// with a scoreboard that predicts every output byte and its unit/run markers
// depends on anbf_pkg and annexb_nal_unit_framer

module annexb_nal_unit_framer_tb;

    import anbf_pkg::*;

    localparam int TOTAL_ITEMS  = 215;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 100;

    class framer_scoreboard;
        int          zero_count;
        logic [7:0]  delayed_byte;
        bit          delayed_valid;
        bit          delayed_first;
        bit          in_unit;
        t_out_item   unit_bytes_q[$];
        int          errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            zero_count    = 0;
            delayed_byte  = BYTE_ZERO;
            delayed_valid = 0;
            delayed_first = 0;
            in_unit       = 0;
        endfunction

        function void emit_byte(logic [7:0] b, bit first, bit last);
            t_out_item r;
            r.out_byte   = b;
            r.unit_first = first;
            r.unit_last  = last;
            r.run_last   = 1'b0;
            unit_bytes_q.push_back(r);
        endfunction

        function void shift_byte(logic [7:0] b, bit first);
            if (delayed_valid)
                emit_byte(delayed_byte, delayed_first, 1'b0);
            delayed_byte  = b;
            delayed_first = first;
            delayed_valid = 1;
        endfunction

        // works out the bytes released by one accepted input transaction
        function void note_input(t_in_item it);
            int base;
            base = unit_bytes_q.size();
            if (it.kind == KIND_EOS) begin
                if (in_unit) begin
                    for (int i = 0; i < zero_count; i++)
                        shift_byte(BYTE_ZERO, 1'b0);
                    if (delayed_valid)
                        emit_byte(delayed_byte, delayed_first, 1'b1);
                end
                clear_state();
            end else if (it.data_byte == BYTE_ZERO) begin
                if (zero_count < MAX_ZEROS)
                    zero_count++;
                else if (in_unit)
                    shift_byte(BYTE_ZERO, 1'b0);
            end else if (it.data_byte == BYTE_ONE && zero_count >= 2) begin
                if (delayed_valid) begin
                    emit_byte(delayed_byte, delayed_first, 1'b1);
                    delayed_valid = 0;
                    delayed_first = 0;
                end
                for (int i = 0; i < zero_count; i++)
                    shift_byte(BYTE_ZERO, i == 0);
                shift_byte(BYTE_ONE, 1'b0);
                in_unit    = 1;
                zero_count = 0;
            end else begin
                if (in_unit) begin
                    for (int i = 0; i < zero_count; i++)
                        shift_byte(BYTE_ZERO, 1'b0);
                    shift_byte(it.data_byte, 1'b0);
                end
                zero_count = 0;
            end
            if (unit_bytes_q.size() > base)
                unit_bytes_q[$].run_last = 1'b1;
        endfunction

        function void check_output(t_out_item got);
            t_out_item want;
            if (unit_bytes_q.size() == 0) begin
                $display("%0t: unexpected output transaction, actual %h", $time, got);
                errors++;
            end else begin
                want = unit_bytes_q.pop_front();
                if (got.out_byte !== want.out_byte || got.unit_first !== want.unit_first ||
                    got.unit_last !== want.unit_last || got.run_last !== want.run_last) begin
                    $display("%0t: mismatch, expected %h/%b/%b/%b, actual %h/%b/%b/%b",
                             $time, want.out_byte, want.unit_first, want.unit_last,
                             want.run_last, got.out_byte, got.unit_first, got.unit_last,
                             got.run_last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return unit_bytes_q.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    framer_scoreboard sb;
    int in_idle_pct;
    int out_idle_pct;
    int hold_requests;
    int items_sent;

    annexb_nal_unit_framer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic drive_item(input t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it.kind      = KIND_DATA;
        it.data_byte = b;
        drive_item(it);
    endtask

    task automatic send_eos();
        t_in_item it;
        it.kind      = KIND_EOS;
        it.data_byte = 8'($urandom_range(255));
        drive_item(it);
    endtask

    task automatic send_start_code(input int zeros);
        repeat (zeros) send_byte(BYTE_ZERO);
        send_byte(BYTE_ONE);
    endtask

    task automatic send_payload(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 12)
                send_byte(BYTE_ZERO);
            else if (r < 18)
                send_byte(BYTE_ONE);
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic set_idling(input int in_pct, input int out_pct);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
    endtask

    // receiver side
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                sb.check_output(o_out_item);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("annexb_nal_unit_framer verification failed");
        $finish;
    end

    initial begin
        int choice;
        int run_len;
        sb            = new();
        hold_requests = 0;
        items_sent    = 0;
        set_idling(14, 52);
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_byte(8'hFF);
        send_byte(BYTE_ZERO);
        send_byte(BYTE_ONE);
        send_start_code(2);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(BYTE_ONE);
        send_byte(BYTE_ZERO);
        send_byte(8'h05);
        send_start_code(3);
        send_byte(BYTE_ZERO);
        send_byte(BYTE_ZERO);
        send_eos();
        send_eos();
        send_byte(BYTE_ZERO);
        send_byte(BYTE_ZERO);
        send_eos();

        // random part
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= 175 && in_idle_pct != 0) begin
                set_idling(0, 0);
            end else if (items_sent >= 100 && in_idle_pct == 14) begin
                set_idling(52, 14);
                hold_requests++;
            end
            choice = $urandom_range(99);
            if (choice < 75) begin
                if ($urandom_range(9) == 0)
                    send_start_code($urandom_range(28, 40));
                else
                    send_start_code($urandom_range(2, 4));
                send_payload($urandom_range(1, 10));
                if ($urandom_range(5) == 0)
                    send_eos();
            end else if (choice < 88) begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
            end else if (choice < 94) begin
                run_len = $urandom_range(1, 6);
                repeat (run_len) send_byte(BYTE_ZERO);
                send_byte(8'($urandom_range(2, 255)));
            end else begin
                send_eos();
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("annexb_nal_unit_framer verification clean");
        else
            $display("annexb_nal_unit_framer verification failed");
        $finish;
    end

endmodule
